/* rtl/core/sha1_hash_engine_macros.svh */
// assertion macros for the sha1 hash engine
`ifndef SHA1_HASH_ENGINE_MACROS_SVH
`define SHA1_HASH_ENGINE_MACROS_SVH

// property must hold whenever reset is released
`define SHA1_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// if antecedent, then consequent in the next cycle
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/sha1_pkg.sv */
`default_nettype none
package sha1_pkg;
  localparam logic [31:0] H0 = 32'h67452301;
  localparam logic [31:0] H1 = 32'hEFCDAB89;
  localparam logic [31:0] H2 = 32'h98BADCFE;
  localparam logic [31:0] H3 = 32'h10325476;
  localparam logic [31:0] H4 = 32'hC3D2E1F0;
  localparam logic [7:0]  PadByte = 8'h80;
  localparam int unsigned FifoDepth = 2;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } item_t;

  function automatic logic [31:0] round_k(input logic [6:0] r);
    logic [31:0] k;
    if (r < 7'd20) k = 32'h5A827999;
    else if (r < 7'd40) k = 32'h6ED9EBA1;
    else if (r < 7'd60) k = 32'h8F1BBCDC;
    else k = 32'hCA62C1D6;
    return k;
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    if (r < 7'd20) f = (b & c) | (~b & d);
    else if (r >= 7'd40 && r < 7'd60) f = (b & c) | (b & d) | (c & d);
    else f = b ^ c ^ d;
    return f;
  endfunction
endpackage
`default_nettype wire

/* rtl/core/sha1_fifo.sv */
`default_nettype none
module sha1_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           wr_valid_i,
  output logic                wr_ready_o,
  input  wire sha1_pkg::item_t wr_item_i,
  output logic                rd_valid_o,
  input  wire logic           rd_ready_i,
  output sha1_pkg::item_t     rd_item_o
);
  import sha1_pkg::*;
  localparam int unsigned PtrW = $clog2(FifoDepth);

  item_t mem_q [FifoDepth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [PtrW:0]   cnt_q;
  logic wr_en, rd_en;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(FifoDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rptr_q];
  assign wr_en = wr_valid_i && wr_ready_o;
  assign rd_en = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (wr_en) wptr_q <= (wptr_q == PtrW'(FifoDepth-1)) ? '0 : wptr_q + 1'b1;
      if (rd_en) rptr_q <= (rptr_q == PtrW'(FifoDepth-1)) ? '0 : rptr_q + 1'b1;
      if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
      else if (rd_en && !wr_en) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wptr_q] <= wr_item_i;
  end
endmodule
`default_nettype wire

/* rtl/core/sha1_front.sv */
`default_nettype none
module sha1_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_valid_i,
  output logic                 s_ready_o,
  input  wire logic [31:0]     s_data_i,
  input  wire logic [2:0]      s_count_i,
  input  wire logic            s_last_i,
  output logic                 q_valid_o,
  input  wire logic            q_ready_i,
  output sha1_pkg::item_t      q_item_o
);
  import sha1_pkg::*;
  logic [2:0]  cnt;
  logic [31:0] mask;
  item_t item;

  // classify: clamp count, mask unused bytes of the final transaction
  always_comb begin
    cnt = s_last_i ? ((s_count_i > 3'd4) ? 3'd4 : s_count_i) : 3'd4;
    case (cnt)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'hFF00_0000;
      3'd2:    mask = 32'hFFFF_0000;
      3'd3:    mask = 32'hFFFF_FF00;
      default: mask = 32'hFFFF_FFFF;
    endcase
    item.data_word  = s_data_i & mask;
    item.byte_count = cnt;
    item.last_word  = s_last_i;
  end

  sha1_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (s_valid_i),
    .wr_ready_o (s_ready_o),
    .wr_item_i  (item),
    .rd_valid_o (q_valid_o),
    .rd_ready_i (q_ready_i),
    .rd_item_o  (q_item_o)
  );
endmodule
`default_nettype wire

/* rtl/core/sha1_back.sv */
`default_nettype none
module sha1_back (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  output logic             q_ready_o,
  input  wire sha1_pkg::item_t q_item_i,
  output logic             m_valid_o,
  input  wire logic        m_ready_i,
  output logic [31:0]      m_digest_o,
  output logic [2:0]       m_index_o,
  output logic             m_final_o
);
  import sha1_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROUND, ST_PAD, ST_ADD, ST_OUT
  } state_e;

  state_e      state_q;
  logic [31:0] h_q [5];
  logic [31:0] v_q [5];
  logic [31:0] w_q [16];
  logic [3:0]  idx_q;
  logic [63:0] bits_q;
  logic [6:0]  rnd_q;
  logic        fin_q;   // compressing the final block, emit afterwards
  logic        pad_q;   // padding pending after this block
  logic        tail_q;  // final transaction taken, padding still in progress
  logic [2:0]  out_q;

  logic [3:0]  s;
  logic [31:0] wx, wr, t;
  logic [31:0] pad_word;
  logic [3:0]  idx_n;

  assign s  = rnd_q[3:0];
  assign wx = w_q[s+4'd13] ^ w_q[s+4'd8] ^ w_q[s+4'd2] ^ w_q[s];
  assign wr = (rnd_q < 7'd16) ? w_q[s] : {wx[30:0], wx[31]};
  assign t  = {v_q[0][26:0], v_q[0][31:27]}
            + round_f(rnd_q, v_q[1], v_q[2], v_q[3]) + v_q[4] + round_k(rnd_q) + wr;

  always_comb begin
    case (q_item_i.byte_count)
      3'd0:    pad_word = {PadByte, 24'h0};
      3'd1:    pad_word = {q_item_i.data_word[31:24], PadByte, 16'h0};
      3'd2:    pad_word = {q_item_i.data_word[31:16], PadByte, 8'h0};
      3'd3:    pad_word = {q_item_i.data_word[31:8], PadByte};
      default: pad_word = q_item_i.data_word;
    endcase
  end

  assign idx_n      = idx_q + 4'd1;
  assign q_ready_o  = (state_q == ST_IDLE);
  assign m_valid_o  = (state_q == ST_OUT);
  assign m_digest_o = h_q[out_q];
  assign m_index_o  = out_q;
  assign m_final_o  = (out_q == 3'd4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
      for (int i = 0; i < 5; i++) v_q[i] <= '0;
      idx_q  <= '0;
      bits_q <= '0;
      rnd_q  <= '0;
      fin_q  <= 1'b0;
      pad_q  <= 1'b0;
      tail_q <= 1'b0;
      out_q  <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (q_valid_i) begin
            bits_q <= bits_q + {58'd0, q_item_i.byte_count, 3'd0};
            w_q[idx_q] <= pad_word;
            idx_q <= idx_n;
            if (!q_item_i.last_word) begin
              if (idx_q == 4'd15) begin
                state_q <= ST_ROUND;
                for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
              end
            end else if (q_item_i.byte_count == 3'd4) begin
              // pad word goes in the next slot, maybe after a full block
              tail_q <= 1'b1;
              if (idx_q == 4'd15) begin
                state_q <= ST_ROUND;
                pad_q <= 1'b1;
                for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
              end else begin
                state_q <= ST_PAD;
                pad_q <= 1'b1;
              end
            end else begin
              tail_q <= 1'b1;
              // pad byte lands in this word; if in the last slot, the block is full
              if (idx_q == 4'd15) begin
                state_q <= ST_ROUND;
                for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
              end else begin
                state_q <= ST_PAD;
              end
            end
          end
        end
        ST_PAD: begin
          // one word per cycle: pad byte, zeros, then length
          if (pad_q) begin
            w_q[idx_q] <= {PadByte, 24'h0};
            pad_q <= 1'b0;
            idx_q <= idx_n;
            if (idx_q == 4'd15) begin
              state_q <= ST_ROUND;
              for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
            end
          end else if (idx_q == 4'd14 && !fin_q) begin
            w_q[14] <= bits_q[63:32];
            idx_q <= idx_n;
            fin_q <= 1'b1;
          end else if (idx_q == 4'd15 && fin_q) begin
            w_q[15] <= bits_q[31:0];
            idx_q <= '0;
            state_q <= ST_ROUND;
            for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
          end else begin
            w_q[idx_q] <= '0;
            idx_q <= idx_n;
            if (idx_q == 4'd15) begin
              state_q <= ST_ROUND;
              for (int i = 0; i < 5; i++) v_q[i] <= h_q[i];
            end
          end
        end
        ST_ROUND: begin
          if (rnd_q >= 7'd16) w_q[s] <= wr;
          v_q[0] <= t;
          v_q[1] <= v_q[0];
          v_q[2] <= {v_q[1][1:0], v_q[1][31:2]};
          v_q[3] <= v_q[2];
          v_q[4] <= v_q[3];
          rnd_q <= (rnd_q == 7'd79) ? '0 : rnd_q + 7'd1;
          if (rnd_q == 7'd79) state_q <= ST_ADD;
        end
        ST_ADD: begin
          for (int i = 0; i < 5; i++) h_q[i] <= h_q[i] + v_q[i];
          if (fin_q) begin
            state_q <= ST_OUT;
            out_q <= '0;
          end else if (tail_q) begin
            state_q <= ST_PAD;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (m_ready_i) begin
            if (out_q == 3'd4) begin
              state_q <= ST_IDLE;
              h_q[0] <= H0; h_q[1] <= H1; h_q[2] <= H2; h_q[3] <= H3; h_q[4] <= H4;
              bits_q <= '0;
              idx_q <= '0;
              fin_q <= 1'b0;
              tail_q <= 1'b0;
              out_q <= '0;
            end else begin
              out_q <= out_q + 3'd1;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

/* rtl/core/sha1_hash_engine.sv */
// a block compresses in 80 rounds, one round per cycle in the back end
// the back end takes no new word while it runs a block: 16 words, then rounds and add
// final word: padding fills one or two blocks, then 5 digest words
// a 2-entry queue decouples the input from the round engine
// reset (rst_ni low, async) loads the initial chaining values and clears length and fill
`default_nettype none
module sha1_hash_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [39:0] s_axis_tdata,  // data_word[31:0], byte_count[34:32], zero fill
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // digest_word[31:0], word_index[34:32], zero fill
  output logic             m_axis_tlast
);
  import sha1_pkg::*;
  `include "sha1_hash_engine_macros.svh"

  logic  q_valid, q_ready;
  item_t q_item;
  logic [31:0] dig;
  logic [2:0]  widx;

  sha1_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata[31:0]),
    .s_count_i (s_axis_tdata[34:32]),
    .s_last_i  (s_axis_tlast),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_item_o  (q_item)
  );

  sha1_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_item_i   (q_item),
    .m_valid_o  (m_axis_tvalid),
    .m_ready_i  (m_axis_tready),
    .m_digest_o (dig),
    .m_index_o  (widx),
    .m_final_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {5'd0, widx, dig};

  `SHA1_ASSERT(a_tlast_idx, m_axis_tvalid |-> (m_axis_tlast == (widx == 3'd4)), "tlast mismatch")
  `SHA1_ASSERT(a_idx_range, m_axis_tvalid |-> (widx <= 3'd4), "word index out of range")
  `SHA1_ASSERT_NEXT(a_idx_step, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && widx == $past(widx) + 3'd1, "digest order broken")
  `SHA1_ASSERT(a_no_take_out, m_axis_tvalid |-> !q_ready, "back end took item while emitting")
endmodule
`default_nettype wire

/* tb/sha1_hash_engine_tb.sv */
`default_nettype none
module sha1_hash_engine_tb;
  import sha1_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
  } digest_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  sha1_hash_engine u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // predictor state
  logic [31:0] chain_q[5];
  logic [31:0] msg_block[16];
  int unsigned fill_bytes;
  logic [63:0] msg_len_bits;

  item_t   word_queue[$];
  digest_t digest_queue[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned phase_sel;
  int unsigned hold_cycles;
  bit          in_taken;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  task automatic load_initial_chain();
    chain_q[0] = H0; chain_q[1] = H1; chain_q[2] = H2;
    chain_q[3] = H3; chain_q[4] = H4;
  endtask

  task automatic compress_block();
    logic [31:0] a, b, c, d, e, f, w, t, kc;
    logic [31:0] sched[16];
    int s;
    sched = msg_block;
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int r = 0; r < 80; r++) begin
      s = r & 15;
      if (r >= 16) begin
        sched[s] = rol(sched[(s + 13) & 15] ^ sched[(s + 8) & 15] ^ sched[(s + 2) & 15] ^
                       sched[s], 1);
      end
      w = sched[s];
      if (r < 20) begin
        f = (b & c) | (~b & d); kc = 32'h5A827999;
      end else if (r < 40) begin
        f = b ^ c ^ d; kc = 32'h6ED9EBA1;
      end else if (r < 60) begin
        f = (b & c) | (b & d) | (c & d); kc = 32'h8F1BBCDC;
      end else begin
        f = b ^ c ^ d; kc = 32'hCA62C1D6;
      end
      t = rol(a, 5) + f + e + kc + w;
      e = d; d = c; c = rol(b, 30); b = a; a = t;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic predict_digest(input item_t it);
    int unsigned idx;
    int unsigned cnt;
    logic [31:0] mask;
    digest_t dw;
    idx = fill_bytes >> 2;
    if (!it.last_word) begin
      msg_block[idx] = it.data_word;
      msg_len_bits += 64'd32;
      fill_bytes = (fill_bytes + 4) & 63;
      if (fill_bytes == 0) compress_block();
      return;
    end
    cnt = (it.byte_count > 4) ? 4 : it.byte_count;
    if (cnt == 4) begin
      msg_block[idx] = it.data_word;
      idx++;
      if (idx == 16) begin
        compress_block();
        idx = 0;
      end
      msg_block[idx] = {PadByte, 24'h0};
    end else begin
      mask = (cnt == 0) ? 32'h0 : (32'hFFFFFFFF << (32 - 8 * cnt));
      msg_block[idx] = (it.data_word & mask) | (32'(PadByte) << (24 - 8 * cnt));
    end
    idx++;
    msg_len_bits += 64'(8 * cnt);
    if (idx > 14) begin
      for (; idx < 16; idx++) msg_block[idx] = '0;
      compress_block();
      idx = 0;
    end
    for (; idx < 14; idx++) msg_block[idx] = '0;
    msg_block[14] = msg_len_bits[63:32];
    msg_block[15] = msg_len_bits[31:0];
    compress_block();
    for (int k = 0; k < 5; k++) begin
      dw.digest_word = chain_q[k];
      dw.word_index  = 3'(k);
      dw.final_word  = (k == 4);
      digest_queue.push_back(dw);
    end
    load_initial_chain();
    fill_bytes = 0;
    msg_len_bits = '0;
  endtask

  task automatic add_word(input logic [31:0] d, input logic [2:0] n, input logic l);
    item_t it;
    it.data_word = d; it.byte_count = n; it.last_word = l;
    word_queue.push_back(it);
  endtask

  // random message; last byte count random including values above four
  task automatic add_message(input int unsigned nwords);
    for (int i = 0; i < nwords; i++) add_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    add_word($urandom, 3'($urandom_range(0, 7)), 1'b1);
  endtask

  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = 1'b1;
      #5 clk_i = 1'b0;
    end
  end

  // driver: in_taken tells whether the offered transaction went in at the last rising edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (in_taken) void'(word_queue.pop_front());
      if (s_axis_tvalid && !in_taken) begin
        // hold the offered transaction
      end else if (word_queue.size() > 0 &&
                   !(phase_sel == 0 && $urandom_range(0, 99) < 23) &&
                   !(phase_sel == 1 && $urandom_range(0, 99) < 60)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {5'b0, word_queue[0].byte_count, word_queue[0].data_word};
        s_axis_tlast  <= word_queue[0].last_word;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, with a long hold-off counted here
  always @(negedge clk_i) begin
    if (hold_cycles != 0) begin
      hold_cycles   <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (phase_sel == 0) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 60);
    end else if (phase_sel == 1) begin
      m_axis_tready <= ($urandom_range(0, 99) >= 23);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor: predict on input acceptance, check on output acceptance
  always @(posedge clk_i) begin
    digest_t got;
    item_t   acc;
    in_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        acc.data_word  = s_axis_tdata[31:0];
        acc.byte_count = s_axis_tdata[34:32];
        acc.last_word  = s_axis_tlast;
        predict_digest(acc);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.digest_word = m_axis_tdata[31:0];
        got.word_index  = m_axis_tdata[34:32];
        got.final_word  = m_axis_tlast;
        if (digest_queue.size() == 0) begin
          $display("%0t unexpected digest transaction: actual %h", $realtime, got);
          error_count++;
        end else if (got !== digest_queue[0] || m_axis_tdata[39:35] !== 5'b0) begin
          $display("%0t digest mismatch: expected %h actual %h (tdata %h)", $realtime,
                   digest_queue[0], got, m_axis_tdata);
          error_count++;
          void'(digest_queue.pop_front());
        end else begin
          void'(digest_queue.pop_front());
        end
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (idle_cycles >= WatchdogLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned queued;
    int unsigned nw;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tlast = 1'b0;
    m_axis_tready = 1'b0;
    error_count = 0;
    idle_cycles = 0;
    phase_sel = 0;
    hold_cycles = 0;
    load_initial_chain();
    foreach (msg_block[i]) msg_block[i] = '0;
    fill_bytes = 0;
    msg_len_bits = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty message, each short final count, extremes, block boundaries
    add_word(32'h0, 3'd0, 1'b1);
    add_word(32'hFFFFFFFF, 3'd1, 1'b1);
    add_word(32'hFFFFFFFF, 3'd2, 1'b1);
    add_word(32'hFFFFFFFF, 3'd3, 1'b1);
    add_word(32'h61626300, 3'd3, 1'b1);
    add_word(32'hFFFFFFFF, 3'd7, 1'b1);
    for (int i = 0; i < 13; i++) add_word(32'hFFFFFFFF, 3'd5, 1'b0);
    add_word(32'h00000000, 3'd4, 1'b1);
    for (int i = 0; i < 15; i++) add_word(32'h00000000, 3'd0, 1'b0);
    add_word(32'hA5A5A5A5, 3'd4, 1'b1);

    // long hold-off so the input backs up
    hold_cycles = 400;
    for (int p = 0; p < 3; p++) begin
      phase_sel = p;
      queued = 0;
      while (queued < 88) begin
        case ($urandom_range(0, 3))
          0: nw = $urandom_range(0, 3);
          1: nw = $urandom_range(12, 17);
          2: nw = $urandom_range(28, 33);
          default: nw = $urandom_range(0, 20);
        endcase
        add_message(nw);
        queued += nw + 1;
      end
      wait (word_queue.size() == 0);
    end
    wait (word_queue.size() == 0 && !s_axis_tvalid);
    wait (digest_queue.size() == 0);
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && digest_queue.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
